>>> hdl/assert_macros.svh
// Assertion macros shared by the heap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge out of reset
`define AMH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define AMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/amh_pkg.sv
// Package: sizes, codes and types of the addressable min-heap.
`default_nettype none
package amh_pkg;
  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = AW + 1;
  localparam int HW        = 10;
  localparam int PW        = 32;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DECREASE = 3'd1,
    OP_DELETE   = 3'd2,
    OP_CHANGE   = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_KEY_LARGER = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_DL1, S_DL2,
    S_UP, S_UP1, S_UP2,
    S_DN, S_DN1, S_DN2, S_DN3, S_DN4,
    S_MIN, S_MIN1, S_MIN2, S_FIN
  } seq_state_t;

  typedef struct packed {
    status_t               status;
    logic [HW-1:0]         result_handle;
    logic [KEY_WIDTH-1:0]  min_key;
    logic [HW-1:0]         min_handle;
    logic [PW-1:0]         min_payload;
    logic [CW-1:0]         entry_count;
    logic                  heap_empty;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;
endpackage
`default_nettype wire

>>> hdl/addressable_min_heap_top.sv
// Addressable binary min-heap: top level with channel handshakes and result register.
//
// Input channel in_*: one operation per item (insert, decrease key, delete,
// change payload, clear). Result channel out_*: exactly one result per item
// with status, handle, current minimum entry and entry count.
// in_ready is high only while the sequencer is idle; one item is worked on at
// a time. Insert and decrease climb the tree level by level; delete sinks or
// climbs the moved last entry level by level, skipping the right-child
// comparison where there is no right child; change payload and items that end
// in an error status skip the walk; clear sweeps all CAPACITY entries (1024).
// The walk is paced by the single read port of the slot and key memories and
// the one shared key comparator.
// Reset: synchronous, active low; afterwards a sweep over all CAPACITY entries
// rebuilds the free handle list and in-use flags, and in_ready stays low.
// When the receiver stalls, the result waits in the output register; the
// sequencer finishes the next item and holds it until the register frees.
`default_nettype none
`include "assert_macros.svh"
module addressable_min_heap_top
  import amh_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [HW-1:0]               in_entry_handle,
  input  wire logic signed [KEY_WIDTH-1:0] in_new_key,
  input  wire logic [PW-1:0]               in_payload,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [HW-1:0]                    out_result_handle,
  output logic signed [KEY_WIDTH-1:0]      out_min_key,
  output logic [HW-1:0]                    out_min_handle,
  output logic [PW-1:0]                    out_min_payload,
  output logic [CW-1:0]                    out_entry_count,
  output logic                             out_heap_empty
);
  seq_stat_t stat;
  result_t   res, out_r;
  logic      out_valid_r, accept, take;

  assign accept = in_valid && in_ready;
  assign take   = stat.done && (!out_valid_r || out_ready);

  amh_seq u_seq (
    .clk, .rst_n, .accept,
    .in_op(in_operation), .in_h(in_entry_handle), .in_key(in_new_key),
    .in_pay(in_payload), .take, .stat, .res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign in_ready          = stat.idle;
  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_result_handle = out_r.result_handle;
  assign out_min_key       = out_r.min_key;
  assign out_min_handle    = out_r.min_handle;
  assign out_min_payload   = out_r.min_payload;
  assign out_entry_count   = out_r.entry_count;
  assign out_heap_empty    = out_r.heap_empty;

  `AMH_ASSERT_NEXT(a_take_valid, clk, rst_n, take, out_valid_r, "result lost on hand-off")
endmodule
`default_nettype wire

>>> hdl/amh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module amh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/amh_cmp.sv
// Shared signed key comparator.
`default_nettype none
module amh_cmp
  import amh_pkg::*;
(
  input  wire logic [KEY_WIDTH-1:0] a,
  input  wire logic [KEY_WIDTH-1:0] b,
  output logic                      lt
);
  assign lt = $signed(a) < $signed(b);
endmodule
`default_nettype wire

>>> hdl/amh_seq.sv
// Heap sequencer: stores, clearing sweep and sift walk.
`default_nettype none
`include "assert_macros.svh"
module amh_seq
  import amh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [2:0]            in_op,
  input  wire logic [HW-1:0]         in_h,
  input  wire logic [KEY_WIDTH-1:0]  in_key,
  input  wire logic [PW-1:0]         in_pay,
  input  wire logic                  take,
  output seq_stat_t                  stat,
  output result_t                    res
);
  seq_state_t state_r, state_nxt;
  logic [AW-1:0] clr_i_r, clr_i_nxt;
  logic clr_rsp_r, clr_rsp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0] op_r, op_nxt;
  logic [HW-1:0] h_r, h_nxt, rh_r, rh_nxt;
  logic [KEY_WIDTH-1:0] k_r, k_nxt, mk_r, mk_nxt, ck_r, ck_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic [AW-1:0] pos_r, pos_nxt, mv_r, mv_nxt, ch_r, ch_nxt, rc_r, rc_nxt;
  logic [CW-1:0] c_r, c_nxt;
  status_t status_r, status_nxt;
  result_t res_r, res_nxt;

  logic inuse_we, inuse_wd, inuse_q;
  logic [AW-1:0] inuse_wa;
  logic free_we;
  logic [AW-1:0] free_wa, free_wd, free_q;
  logic key_we;
  logic [AW-1:0] key_wa, key_ra;
  logic [KEY_WIDTH-1:0] key_wd, key_q;
  logic pay_we;
  logic [AW-1:0] pay_wa;
  logic [PW-1:0] pay_wd, pay_q;
  logic slots_we;
  logic [AW-1:0] slots_wa, slots_wd, slots_ra, slots_q;
  logic posm_we;
  logic [AW-1:0] posm_wa, posm_wd, pos_q;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic cmp_lt, hv;
  logic [AW-1:0] par;
  logic [CW-1:0] c_new, c1, cnt_m1;

  amh_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_inuse (
    .clk, .we(inuse_we), .waddr(inuse_wa), .wdata(inuse_wd),
    .raddr(in_h[AW-1:0]), .rdata(inuse_q));
  amh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
    .clk, .we(free_we), .waddr(free_wa), .wdata(free_wd),
    .raddr(cnt_r[AW-1:0]), .rdata(free_q));
  amh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd),
    .raddr(key_ra), .rdata(key_q));
  amh_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pay (
    .clk, .we(pay_we), .waddr(pay_wa), .wdata(pay_wd),
    .raddr(slots_q), .rdata(pay_q));
  amh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_slots (
    .clk, .we(slots_we), .waddr(slots_wa), .wdata(slots_wd),
    .raddr(slots_ra), .rdata(slots_q));
  amh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pos (
    .clk, .we(posm_we), .waddr(posm_wa), .wdata(posm_wd),
    .raddr(in_h[AW-1:0]), .rdata(pos_q));

  amh_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt));

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_FIN);
  assign res       = res_r;

  assign hv     = inuse_q && (CW'(h_r) < CW'(CAPACITY));
  assign par    = (pos_r - AW'(1)) >> 1;
  assign c_new  = {pos_r, 1'b1};
  assign c1     = c_r + CW'(1);
  assign cnt_m1 = cnt_r - CW'(1);
  assign key_ra = (state_r == S_IDLE) ? in_h[AW-1:0] : slots_q;

  always_comb begin
    unique case (state_r)
      S_DISP:  slots_ra = cnt_m1[AW-1:0];
      S_UP:    slots_ra = par;
      S_DN:    slots_ra = c_new[AW-1:0];
      S_DN1:   slots_ra = c1[AW-1:0];
      default: slots_ra = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;   clr_i_nxt = clr_i_r;  clr_rsp_nxt = clr_rsp_r;
    cnt_nxt = cnt_r;       op_nxt = op_r;        h_nxt = h_r;
    k_nxt = k_r;           pay_nxt = pay_r;      rh_nxt = rh_r;
    mk_nxt = mk_r;         ck_nxt = ck_r;        pos_nxt = pos_r;
    mv_nxt = mv_r;         ch_nxt = ch_r;        rc_nxt = rc_r;
    c_nxt = c_r;           status_nxt = status_r; res_nxt = res_r;
    inuse_we = 1'b0; inuse_wa = '0; inuse_wd = 1'b0;
    free_we = 1'b0;  free_wa = '0;  free_wd = '0;
    key_we = 1'b0;   key_wa = '0;   key_wd = '0;
    pay_we = 1'b0;   pay_wa = '0;   pay_wd = '0;
    slots_we = 1'b0; slots_wa = '0; slots_wd = '0;
    posm_we = 1'b0;  posm_wa = '0;  posm_wd = '0;
    cmp_a = '0;      cmp_b = '0;
    unique case (state_r)
      S_CLEAR: begin
        inuse_we = 1'b1; inuse_wa = clr_i_r; inuse_wd = 1'b0;
        free_we = 1'b1;  free_wa = clr_i_r;  free_wd = clr_i_r;
        if (clr_i_r == AW'(CAPACITY - 1)) begin
          state_nxt = clr_rsp_r ? S_MIN : S_IDLE;
          clr_rsp_nxt = 1'b0;
        end else begin
          clr_i_nxt = clr_i_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_op; h_nxt = in_h; k_nxt = in_key; pay_nxt = in_pay;
          status_nxt = ST_OK; rh_nxt = in_h;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmp_a = key_q; cmp_b = k_r;
        state_nxt = S_MIN;
        case (op_r)
          OP_INSERT: begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL; rh_nxt = '0;
            end else begin
              inuse_we = 1'b1; inuse_wa = free_q; inuse_wd = 1'b1;
              key_we = 1'b1;   key_wa = free_q;   key_wd = k_r;
              pay_we = 1'b1;   pay_wa = free_q;   pay_wd = pay_r;
              cnt_nxt = cnt_r + CW'(1);
              mv_nxt = free_q; mk_nxt = k_r; pos_nxt = cnt_r[AW-1:0];
              rh_nxt = HW'(free_q);
              state_nxt = S_UP;
            end
          end
          OP_DECREASE: begin
            if (!hv) begin
              status_nxt = ST_BAD_HANDLE;
            end else if (cmp_lt) begin
              status_nxt = ST_KEY_LARGER;
            end else begin
              key_we = 1'b1; key_wa = h_r[AW-1:0]; key_wd = k_r;
              mv_nxt = h_r[AW-1:0]; mk_nxt = k_r; pos_nxt = pos_q;
              state_nxt = S_UP;
            end
          end
          OP_DELETE: begin
            if (!hv) begin
              status_nxt = ST_BAD_HANDLE;
            end else begin
              inuse_we = 1'b1; inuse_wa = h_r[AW-1:0]; inuse_wd = 1'b0;
              free_we = 1'b1;  free_wa = cnt_m1[AW-1:0]; free_wd = h_r[AW-1:0];
              cnt_nxt = cnt_m1; pos_nxt = pos_q; ck_nxt = key_q;
              state_nxt = S_DL1;
            end
          end
          OP_CHANGE: begin
            if (!hv) begin
              status_nxt = ST_BAD_HANDLE;
            end else begin
              pay_we = 1'b1; pay_wa = h_r[AW-1:0]; pay_wd = pay_r;
            end
          end
          OP_CLEAR: begin
            cnt_nxt = '0; rh_nxt = '0; clr_i_nxt = '0; clr_rsp_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end
          default: state_nxt = S_MIN;
        endcase
      end
      S_DL1: begin
        mv_nxt = slots_q;
        state_nxt = (slots_q == h_r[AW-1:0]) ? S_MIN : S_DL2;
      end
      S_DL2: begin
        mk_nxt = key_q;
        cmp_a = ck_r; cmp_b = key_q;
        state_nxt = cmp_lt ? S_DN : S_UP;
      end
      S_UP: begin
        if (pos_r == '0) begin
          slots_we = 1'b1; slots_wa = pos_r; slots_wd = mv_r;
          posm_we = 1'b1;  posm_wa = mv_r;   posm_wd = pos_r;
          state_nxt = S_MIN;
        end else begin
          state_nxt = S_UP1;
        end
      end
      S_UP1: begin
        ch_nxt = slots_q;
        state_nxt = S_UP2;
      end
      S_UP2: begin
        cmp_a = mk_r; cmp_b = key_q;
        slots_we = 1'b1; slots_wa = pos_r;
        posm_we = 1'b1;  posm_wd = pos_r;
        if (cmp_lt) begin
          slots_wd = ch_r; posm_wa = ch_r;
          pos_nxt = par;
          state_nxt = S_UP;
        end else begin
          slots_wd = mv_r; posm_wa = mv_r;
          state_nxt = S_MIN;
        end
      end
      S_DN: begin
        c_nxt = c_new;
        if (c_new >= cnt_r) begin
          slots_we = 1'b1; slots_wa = pos_r; slots_wd = mv_r;
          posm_we = 1'b1;  posm_wa = mv_r;   posm_wd = pos_r;
          state_nxt = S_MIN;
        end else begin
          state_nxt = S_DN1;
        end
      end
      S_DN1: begin
        ch_nxt = slots_q;
        state_nxt = S_DN2;
      end
      S_DN2: begin
        ck_nxt = key_q; rc_nxt = slots_q;
        state_nxt = (c1 < cnt_r) ? S_DN3 : S_DN4;
      end
      S_DN3: begin
        cmp_a = key_q; cmp_b = ck_r;
        if (cmp_lt) begin
          c_nxt = c1; ch_nxt = rc_r; ck_nxt = key_q;
        end
        state_nxt = S_DN4;
      end
      S_DN4: begin
        cmp_a = ck_r; cmp_b = mk_r;
        slots_we = 1'b1; slots_wa = pos_r;
        posm_we = 1'b1;  posm_wd = pos_r;
        if (cmp_lt) begin
          slots_wd = ch_r; posm_wa = ch_r;
          pos_nxt = c_r[AW-1:0];
          state_nxt = S_DN;
        end else begin
          slots_wd = mv_r; posm_wa = mv_r;
          state_nxt = S_MIN;
        end
      end
      S_MIN: state_nxt = S_MIN1;
      S_MIN1: begin
        ch_nxt = slots_q;
        state_nxt = S_MIN2;
      end
      S_MIN2: begin
        res_nxt.status        = status_r;
        res_nxt.result_handle = rh_r;
        res_nxt.entry_count   = cnt_r;
        res_nxt.heap_empty    = (cnt_r == '0);
        if (cnt_r == '0) begin
          res_nxt.min_key = '0; res_nxt.min_handle = '0; res_nxt.min_payload = '0;
        end else begin
          res_nxt.min_key     = key_q;
          res_nxt.min_handle  = HW'(ch_r);
          res_nxt.min_payload = pay_q;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_i_r   <= '0;
      clr_rsp_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_i_r   <= clr_i_nxt;
      clr_rsp_r <= clr_rsp_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;   h_r <= h_nxt;     k_r <= k_nxt;     pay_r <= pay_nxt;
    rh_r <= rh_nxt;   mk_r <= mk_nxt;   ck_r <= ck_nxt;   pos_r <= pos_nxt;
    mv_r <= mv_nxt;   ch_r <= ch_nxt;   rc_r <= rc_nxt;   c_r <= c_nxt;
    status_r <= status_nxt;
    res_r <= res_nxt;
  end

  `AMH_ASSERT(a_cnt_cap, clk, rst_n, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  `AMH_ASSERT(a_dn_pos, clk, rst_n, (state_r != S_DN) || (CW'(pos_r) < cnt_r), "sift down slot beyond count")
endmodule
`default_nettype wire

>>> test/tb_addressable_min_heap_top.sv
// Testbench for the addressable min-heap: random handshakes, self-checking against a heap model.
`timescale 1ns / 100ps
`default_nettype none
module tb_addressable_min_heap_top;
  import amh_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic [HW-1:0]      hdl;
    logic signed [31:0] key;
    logic [PW-1:0]      pay;
  } heap_cmd_t;

  typedef struct {
    status_t            status;
    logic [HW-1:0]      rhandle;
    logic signed [31:0] mkey;
    logic [HW-1:0]      mhandle;
    logic [PW-1:0]      mpay;
    logic [CW-1:0]      count;
    logic               empty;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [HW-1:0] in_entry_handle = '0;
  logic signed [KEY_WIDTH-1:0] in_new_key = '0;
  logic [PW-1:0] in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [HW-1:0] out_result_handle;
  logic signed [KEY_WIDTH-1:0] out_min_key;
  logic [HW-1:0] out_min_handle;
  logic [PW-1:0] out_min_payload;
  logic [CW-1:0] out_entry_count;
  logic out_heap_empty;

  addressable_min_heap_top dut (.*);

  always #6 clk = ~clk;

  // heap model state
  logic [HW-1:0] slot_m [CAPACITY];
  logic signed [31:0] key_m [CAPACITY];
  logic [PW-1:0] pay_m [CAPACITY];
  int unsigned pos_m [CAPACITY];
  bit used_m [CAPACITY];
  logic [HW-1:0] free_m [CAPACITY];
  int unsigned held;

  heap_cmd_t cmd_q[$];
  heap_res_t exp_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_full = 0, n_bad = 0, n_larger = 0;
  bit hold_tx = 1'b0;

  function automatic void model_clear();
    for (int i = 0; i < CAPACITY; i++) begin
      used_m[i] = 1'b0;
      free_m[i] = i[HW-1:0];
    end
    held = 0;
  endfunction

  function automatic void put_slot(int unsigned p, logic [HW-1:0] h);
    slot_m[p] = h;
    pos_m[h] = p;
  endfunction

  function automatic void climb(int unsigned p, logic [HW-1:0] h);
    int unsigned par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!(key_m[slot_m[par]] > key_m[h])) break;
      put_slot(p, slot_m[par]);
      p = par;
    end
    put_slot(p, h);
  endfunction

  function automatic void sink(int unsigned p, logic [HW-1:0] h);
    int unsigned c;
    forever begin
      c = 2 * p + 1;
      if (c >= held) break;
      if (c + 1 < held && key_m[slot_m[c + 1]] < key_m[slot_m[c]]) c = c + 1;
      if (key_m[h] <= key_m[slot_m[c]]) break;
      put_slot(p, slot_m[c]);
      p = c;
    end
    put_slot(p, h);
  endfunction

  function automatic heap_res_t heap_apply(heap_cmd_t c);
    heap_res_t r;
    logic [HW-1:0] nh, last;
    bit ok;
    ok = used_m[c.hdl];
    r.status = ST_OK;
    r.rhandle = c.hdl;
    case (c.op)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
          r.rhandle = '0;
        end else begin
          nh = free_m[held];
          used_m[nh] = 1'b1;
          key_m[nh] = c.key;
          pay_m[nh] = c.pay;
          held++;
          climb(held - 1, nh);
          r.rhandle = nh;
        end
      end
      OP_DECREASE: begin
        if (!ok) r.status = ST_BAD_HANDLE;
        else if (c.key > key_m[c.hdl]) r.status = ST_KEY_LARGER;
        else begin
          key_m[c.hdl] = c.key;
          climb(pos_m[c.hdl], c.hdl);
        end
      end
      OP_DELETE: begin
        if (!ok) r.status = ST_BAD_HANDLE;
        else begin
          last = slot_m[held - 1];
          held--;
          if (last != c.hdl) begin
            if (key_m[last] > key_m[c.hdl]) sink(pos_m[c.hdl], last);
            else climb(pos_m[c.hdl], last);
          end
          used_m[c.hdl] = 1'b0;
          free_m[held] = c.hdl;
        end
      end
      OP_CHANGE: begin
        if (!ok) r.status = ST_BAD_HANDLE;
        else pay_m[c.hdl] = c.pay;
      end
      OP_CLEAR: begin
        model_clear();
        r.rhandle = '0;
      end
      default: ;
    endcase
    if (held > 0) begin
      r.mkey = key_m[slot_m[0]];
      r.mhandle = slot_m[0];
      r.mpay = pay_m[slot_m[0]];
    end else begin
      r.mkey = '0;
      r.mhandle = '0;
      r.mpay = '0;
    end
    r.count = held[CW-1:0];
    r.empty = (held == 0);
    return r;
  endfunction

  // stimulus-side shadow of live handles, kept in step with the model
  logic [HW-1:0] live_q[$];
  int unsigned shadow_held = 0;

  function automatic logic [HW-1:0] pick_handle();
    if (live_q.size() > 0 && $urandom_range(0, 9) < 8)
      return live_q[$urandom_range(0, live_q.size() - 1)];
    return HW'($urandom_range(0, CAPACITY - 1));
  endfunction

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15) - 8;
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7fff_fffc + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(logic [2:0] op, logic [HW-1:0] h, logic signed [31:0] k,
                          logic [PW-1:0] p);
    heap_cmd_t c;
    c.op = op; c.hdl = h; c.key = k; c.pay = p;
    cmd_q.push_back(c);
  endtask

  // driver
  int gap = 0;
  heap_cmd_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      exp_q.push_back(heap_apply(cur));
      n_sent++;
      gap = ($urandom_range(0, 9) < 7) ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40));
      if (gap == 0 && cmd_q.size() > 0 && !hold_tx) begin
        cur = cmd_q.pop_front();
        in_operation <= cur.op; in_entry_handle <= cur.hdl;
        in_new_key <= cur.key; in_payload <= cur.pay;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap > 0) gap--;
      else if (cmd_q.size() > 0 && !hold_tx) begin
        cur = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= cur.op; in_entry_handle <= cur.hdl;
        in_new_key <= cur.key; in_payload <= cur.pay;
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    heap_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_got++;
        if (exp_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          e = exp_q.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_result_handle !== e.rhandle) begin
            $error("result_handle exp %0d got %0d", e.rhandle, out_result_handle); errors++;
          end
          if (out_min_key !== e.mkey) begin
            $error("min_key exp %0d got %0d", e.mkey, out_min_key); errors++;
          end
          if (out_min_handle !== e.mhandle) begin
            $error("min_handle exp %0d got %0d", e.mhandle, out_min_handle); errors++;
          end
          if (out_min_payload !== e.mpay) begin
            $error("min_payload exp %h got %h", e.mpay, out_min_payload); errors++;
          end
          if (out_entry_count !== e.count) begin
            $error("entry_count exp %0d got %0d", e.count, out_entry_count); errors++;
          end
          if (out_heap_empty !== e.empty) begin
            $error("heap_empty exp %0d got %0d", e.empty, out_heap_empty); errors++;
          end
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_BAD_HANDLE) n_bad++;
          if (e.status == ST_KEY_LARGER) n_larger++;
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // shadow tracking for handle choice: mirrors insert/delete/clear outcomes
  task automatic gen_random(int n);
    logic [2:0] op;
    logic [HW-1:0] h;
    int idx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0,1,2,3,4,5,6,7: op = OP_INSERT;
        8,9,10: op = OP_DECREASE;
        11,12,13,14: op = OP_DELETE;
        15,16,17: op = OP_CHANGE;
        18: op = ($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_INSERT;
        default: op = 3'($urandom_range(5, 7));
      endcase
      h = pick_handle();
      if (op == OP_INSERT && shadow_held < CAPACITY) begin
        // handle assigned follows the free stack; learn it later via live_q refresh
        shadow_held++;
      end else if (op == OP_DELETE) begin
        for (idx = 0; idx < live_q.size(); idx++)
          if (live_q[idx] == h) begin
            live_q.delete(idx);
            shadow_held--;
            break;
          end
      end else if (op == OP_CLEAR) begin
        live_q.delete();
        shadow_held = 0;
      end
      push_cmd(op, h, pick_key(), $urandom);
    end
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0 && !in_valid);
    wait (exp_q.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  // rebuild the live handle list from the model once idle
  task automatic sync_live();
    live_q.delete();
    for (int i = 0; i < CAPACITY; i++) if (used_m[i]) live_q.push_back(i[HW-1:0]);
    shadow_held = held;
  endtask

  initial begin
    model_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed part
    push_cmd(OP_DELETE, 10'd0, 0, 0);
    push_cmd(OP_DECREASE, 10'h3ff, 0, 0);
    push_cmd(OP_CHANGE, 10'd5, 0, 32'hffff_ffff);
    push_cmd(OP_INSERT, 10'h3ff, 32'sh7fff_ffff, 32'hffff_ffff);
    push_cmd(OP_INSERT, 10'd0, 32'sh8000_0000, 32'h0);
    push_cmd(OP_INSERT, 10'd0, 5, 32'haaaa_5555);
    push_cmd(OP_INSERT, 10'd0, 5, 32'h5555_aaaa);
    push_cmd(OP_DECREASE, 10'd2, 6, 0);
    push_cmd(OP_DECREASE, 10'd2, 5, 0);
    push_cmd(OP_DECREASE, 10'd0, 32'sh8000_0000, 0);
    push_cmd(OP_DECREASE, 10'd3, 32'sh8000_0000, 0);
    push_cmd(OP_CHANGE, 10'd3, 32'h1234_5678, 32'hdead_beef);
    push_cmd(OP_DELETE, 10'd3, 0, 0);
    push_cmd(OP_DELETE, 10'd3, 0, 0);
    push_cmd(3'd5, 10'h2aa, 32'sh5555_5555, 0);
    push_cmd(3'd7, 10'h155, 0, 0);
    push_cmd(OP_DELETE, 10'd1, 0, 0);
    push_cmd(OP_CLEAR, 10'h3ff, 0, 0);
    push_cmd(OP_INSERT, 10'd0, -1, 32'h1);
    drain();
    sync_live();
    for (int r = 0; r < 8; r++) begin
      gen_random(36);
      if (r == 3) begin
        hold_tx = 1'b1;
        wait (cmd_q.size() > 0 && !in_valid);
        wait (exp_q.size() == 0);
        hold_tx = 1'b0;
      end
      drain();
      sync_live();
    end
    gen_random(30);
    drain();
    sync_live();
    while (live_q.size() > 0) push_cmd(OP_DELETE, live_q.pop_back(), 0, 0);
    push_cmd(OP_DELETE, 10'd0, 0, 0);
    drain();
    repeat (50) @(posedge clk);
    $display("%0d items sent, %0d results: %0d full, %0d bad handle, %0d larger key",
             n_sent, n_got, n_full, n_bad, n_larger);
    if (errors == 0 && exp_q.size() == 0)
      $display("tb_addressable_min_heap_top passed");
    else
      $display("tb_addressable_min_heap_top failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_addressable_min_heap_top failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/amh_pkg.sv
hdl/amh_ram.sv
hdl/amh_cmp.sv
hdl/amh_seq.sv
hdl/addressable_min_heap_top.sv
test/tb_addressable_min_heap_top.sv
